### rtl/mhfp_pkg.sv
// Package: shared types, codes and helpers for the mail header field parser.
`timescale 1ns / 1ps
package mhfp_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  // result kinds
  localparam logic [2:0] K_NAME   = 3'd0;
  localparam logic [2:0] K_VALUE  = 3'd1;
  localparam logic [2:0] K_FIELD  = 3'd2;
  localparam logic [2:0] K_HEADER = 3'd3;
  localparam logic [2:0] K_ERROR  = 3'd4;

  // parser phases
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_LINE     = 3'd1;
  localparam logic [2:0] PH_AFTER_NL = 3'd2;
  localparam logic [2:0] PH_WS_RUN   = 3'd3;
  localparam logic [2:0] PH_SKIP     = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // up to three results caused by one input byte
  typedef struct packed {
    logic [1:0]       cnt;
    logic [2:0][2:0]  kind;
    logic [2:0][7:0]  data;
  } bundle_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [7:0] data;
    logic       in_value;
    logic       value_started;
  } content_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // one content byte: name byte, colon, or value byte
  function automatic content_t content_f(input logic iv, input logic vs,
                                         input logic [7:0] c);
    content_t r;
    r.emit          = 1'b0;
    r.kind          = K_NAME;
    r.data          = c;
    r.in_value      = iv;
    r.value_started = vs;
    if (!iv) begin
      if (c == CH_COLON) begin
        r.in_value = 1'b1;
      end else begin
        r.emit = 1'b1;
      end
    end else if (vs || !is_blank(c)) begin
      r.value_started = 1'b1;
      r.emit          = 1'b1;
      r.kind          = K_VALUE;
    end
    return r;
  endfunction

endpackage

### rtl/mail_header_field_parser_top.sv
// Top level of the mail header field parser: front end, bundle queue, back end.
`timescale 1ns / 1ps
// A taken byte's results are registered in the queue and sent after all earlier words.
// Throughput: one byte per cycle while the queue has room; the output sends one word
//   per cycle while m_tready is high; a byte with k results (k = 0..3) gives k words.
// The queue depth (QUEUE_DEPTH bundles) sets how far the input may run ahead.
// Reset (rst, synchronous, active high) empties the queue and returns the parser to
//   line start with no field open.
module mail_header_field_parser_top import mhfp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] out_kind, [10:3] out_byte, [15:11] zero
  output logic        m_tlast    // final word caused by one input byte
);

  bundle_t    fr_bundle;
  bundle_t    head;
  logic       q_full, q_empty, q_pop, accept;
  logic [2:0] out_kind;
  logic [7:0] out_byte;

  // a byte is taken whenever the queue has a free slot; bytes with no result
  // only update parse state and push nothing
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  mhfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (s_tdata),
    .bundle  (fr_bundle)
  );

  mhfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && (fr_bundle.cnt != 2'd0)),
    .push_data (fr_bundle),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  mhfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .m_tlast  (m_tlast)
  );

  assign m_tdata = {5'd0, out_byte, out_kind};

endmodule

### rtl/mhfp_front.sv
// Front end: takes one byte a cycle on accept, updates parse state, builds a bundle.
`timescale 1ns / 1ps
module mhfp_front import mhfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  output bundle_t       bundle
);

  logic [2:0] phase, phase_next;
  logic       in_value, in_value_next;
  logic       value_started, value_started_next;
  logic [7:0] held_blank, held_blank_next;

  always_comb begin
    content_t   cr;
    logic [1:0] n;
    logic       ok;
    logic [7:0] c;
    c                  = in_byte;
    phase_next         = phase;
    in_value_next      = in_value;
    value_started_next = value_started;
    held_blank_next    = held_blank;
    n                  = 2'd0;
    ok                 = 1'b0;
    cr                 = '0;
    bundle             = '0;
    case (phase)
      PH_START: begin
        if (c == CH_NUL) begin
          bundle.kind[n] = K_HEADER; n = n + 2'd1;
        end else if (c == CH_NL) begin
          bundle.kind[n] = K_HEADER; n = n + 2'd1;
          phase_next = PH_SKIP;
        end else if (is_blank(c)) begin
          held_blank_next = c;
          phase_next      = PH_WS_RUN;
        end else begin
          cr = content_f(in_value_next, value_started_next, c);
          in_value_next = cr.in_value; value_started_next = cr.value_started;
          if (cr.emit) begin
            bundle.kind[n] = cr.kind; bundle.data[n] = cr.data; n = n + 2'd1;
          end
          phase_next = PH_LINE;
        end
      end
      PH_LINE: begin
        if (c == CH_NUL) begin
          ok = in_value_next;
          bundle.kind[n] = ok ? K_FIELD : K_ERROR; n = n + 2'd1;
          if (ok) begin
            bundle.kind[n] = K_HEADER; n = n + 2'd1;
          end
          in_value_next = 1'b0; value_started_next = 1'b0;
          phase_next = PH_START;
        end else if (c == CH_NL) begin
          phase_next = PH_AFTER_NL;
        end else begin
          cr = content_f(in_value_next, value_started_next, c);
          in_value_next = cr.in_value; value_started_next = cr.value_started;
          if (cr.emit) begin
            bundle.kind[n] = cr.kind; bundle.data[n] = cr.data; n = n + 2'd1;
          end
        end
      end
      PH_AFTER_NL: begin
        if (is_blank(c)) begin
          held_blank_next = c;
          phase_next      = PH_WS_RUN;
        end else begin
          // field ends here: the byte is not a continuation
          ok = in_value_next;
          bundle.kind[n] = ok ? K_FIELD : K_ERROR; n = n + 2'd1;
          in_value_next = 1'b0; value_started_next = 1'b0;
          if (!ok) begin
            phase_next = (c == CH_NUL) ? PH_START : PH_SKIP;
          end else if (c == CH_NUL) begin
            bundle.kind[n] = K_HEADER; n = n + 2'd1;
            phase_next = PH_START;
          end else if (c == CH_NL) begin
            bundle.kind[n] = K_HEADER; n = n + 2'd1;
            phase_next = PH_SKIP;
          end else begin
            cr = content_f(in_value_next, value_started_next, c);
            in_value_next = cr.in_value; value_started_next = cr.value_started;
            if (cr.emit) begin
              bundle.kind[n] = cr.kind; bundle.data[n] = cr.data; n = n + 2'd1;
            end
            phase_next = PH_LINE;
          end
        end
      end
      PH_WS_RUN: begin
        if (is_blank(c)) begin
          held_blank_next = c;
        end else begin
          // the run collapses to its last blank
          cr = content_f(in_value_next, value_started_next, held_blank);
          in_value_next = cr.in_value; value_started_next = cr.value_started;
          if (cr.emit) begin
            bundle.kind[n] = cr.kind; bundle.data[n] = cr.data; n = n + 2'd1;
          end
          if (c == CH_NUL) begin
            ok = in_value_next;
            bundle.kind[n] = ok ? K_FIELD : K_ERROR; n = n + 2'd1;
            if (ok) begin
              bundle.kind[n] = K_HEADER; n = n + 2'd1;
            end
            in_value_next = 1'b0; value_started_next = 1'b0;
            phase_next = PH_START;
          end else if (c == CH_NL) begin
            phase_next = PH_AFTER_NL;
          end else begin
            cr = content_f(in_value_next, value_started_next, c);
            in_value_next = cr.in_value; value_started_next = cr.value_started;
            if (cr.emit) begin
              bundle.kind[n] = cr.kind; bundle.data[n] = cr.data; n = n + 2'd1;
            end
            phase_next = PH_LINE;
          end
        end
      end
      default: begin
        // skipping body or bad field until end of text
        if (c == CH_NUL) begin
          phase_next = PH_START;
        end
      end
    endcase
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      in_value      <= 1'b0;
      value_started <= 1'b0;
      held_blank    <= 8'd0;
    end else if (accept) begin
      phase         <= phase_next;
      in_value      <= in_value_next;
      value_started <= value_started_next;
      held_blank    <= held_blank_next;
    end
  end

endmodule

### rtl/mhfp_queue.sv
// Short bundle queue between parser front end and output back end.
`timescale 1ns / 1ps
module mhfp_queue import mhfp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    empty,
  output bundle_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/mhfp_back.sv
// Back end: walks the head bundle, one result word per ready cycle.
`timescale 1ns / 1ps
module mhfp_back import mhfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     empty,
  input  bundle_t  head,
  output logic     pop,
  output logic     m_tvalid,
  input  logic     m_tready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic     m_tlast
);

  logic [1:0] idx;

  assign m_tvalid = !empty;
  assign out_kind = head.kind[idx];
  assign out_byte = head.data[idx];
  assign m_tlast  = (idx == head.cnt - 2'd1);
  assign pop      = m_tvalid && m_tready && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      idx <= m_tlast ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

### rtl/mhfp_checker.sv
// Port-level checker for the mail header field parser, bound to the top level.
`timescale 1ns / 1ps
module mhfp_checker import mhfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // only kinds name..error are ever sent, with the pad bits clear
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= K_ERROR) && (m_tdata[15:11] == 5'd0))
    else $error("bad result kind or pad bits");

  // marker kinds carry a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] != K_NAME) && (m_tdata[2:0] != K_VALUE))
      |-> (m_tdata[10:3] == 8'd0))
    else $error("marker word with nonzero byte");

  // header done and error always close the results of their byte
  a_terminal_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tdata[2:0] == K_HEADER) || (m_tdata[2:0] == K_ERROR)))
      |-> m_tlast)
    else $error("header done or error not last");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output word changed under stall");

endmodule

bind mail_header_field_parser_top mhfp_checker u_mhfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### tb/tb.sv
// Testbench for the mail header field parser: random text bytes, predicted result words.
`timescale 1ns / 1ps
module tb;
  import mhfp_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with nothing moving before giving up
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off to back up the queue
  localparam int DRAIN_CYCLES = 20;   // settle time after the last expected word

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [2:0] out_kind, [10:3] out_byte, [15:11] zero
  logic        m_tlast;

  logic [7:0] text_bytes[$];      // bytes waiting to be sent
  word_t      pending_words[$];   // predicted words not yet seen on the output
  word_t      byte_words[$];      // words caused by the byte being parsed
  word_t      got_word;

  int snd_idle = 0;               // percent of cycles the sender holds back
  int rcv_idle = 0;               // percent of cycles the receiver stalls
  int hold_seq = 0;               // bumped to request a long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int counted;

  // parser state as the predictor sees it
  logic [2:0] scan_phase = PH_START;
  logic       in_val = 1'b0;      // colon of this field seen
  logic       val_seen = 1'b0;    // first non-blank value byte seen
  logic [7:0] last_blank = 8'h00;

  mail_header_field_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic void put_word(input logic [2:0] kind, input logic [7:0] b);
    word_t w;
    w.kind = kind;
    w.data = b;
    w.last = 1'b0;
    byte_words.push_back(w);
  endfunction

  // name byte, the splitting colon, or a value byte (leading blanks dropped)
  function automatic void feed_content(input logic [7:0] c);
    if (!in_val) begin
      if (c == CH_COLON) in_val = 1'b1;
      else put_word(K_NAME, c);
    end else if (val_seen || !blank(c)) begin
      val_seen = 1'b1;
      put_word(K_VALUE, c);
    end
  endfunction

  // closes the open field; a field without a colon is an error
  function automatic bit close_field();
    bit ok;
    ok = in_val;
    put_word(ok ? K_FIELD : K_ERROR, 8'h00);
    in_val = 1'b0;
    val_seen = 1'b0;
    return ok;
  endfunction

  function automatic void close_text();
    if (close_field()) put_word(K_HEADER, 8'h00);
    scan_phase = PH_START;
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    byte_words.delete();
    case (scan_phase)
      PH_START: begin
        if (c == CH_NUL) begin
          put_word(K_HEADER, 8'h00);
        end else if (c == CH_NL) begin
          put_word(K_HEADER, 8'h00);
          scan_phase = PH_SKIP;
        end else if (blank(c)) begin
          last_blank = c;
          scan_phase = PH_WS_RUN;
        end else begin
          feed_content(c);
          scan_phase = PH_LINE;
        end
      end
      PH_LINE: begin
        if (c == CH_NUL) close_text();
        else if (c == CH_NL) scan_phase = PH_AFTER_NL;
        else feed_content(c);
      end
      PH_AFTER_NL: begin
        // the field only ends once the next line proves not to be a fold
        if (blank(c)) begin
          last_blank = c;
          scan_phase = PH_WS_RUN;
        end else if (!close_field()) begin
          scan_phase = (c == CH_NUL) ? PH_START : PH_SKIP;
        end else if (c == CH_NUL) begin
          put_word(K_HEADER, 8'h00);
          scan_phase = PH_START;
        end else if (c == CH_NL) begin
          put_word(K_HEADER, 8'h00);
          scan_phase = PH_SKIP;
        end else begin
          feed_content(c);
          scan_phase = PH_LINE;
        end
      end
      PH_WS_RUN: begin
        if (blank(c)) begin
          last_blank = c;
        end else begin
          feed_content(last_blank);   // the run collapses to its last blank
          if (c == CH_NUL) begin
            close_text();
          end else if (c == CH_NL) begin
            scan_phase = PH_AFTER_NL;
          end else begin
            feed_content(c);
            scan_phase = PH_LINE;
          end
        end
      end
      default: begin
        // skipping body or a broken header until end of text
        if (c == CH_NUL) scan_phase = PH_START;
      end
    endcase
    if (byte_words.size() != 0) byte_words[byte_words.size() - 1].last = 1'b1;
    foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (text_bytes.size() != 0 && $urandom_range(99) >= snd_idle) begin
        s_tvalid <= 1'b1;
        s_tdata  <= text_bytes.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          got_word = pending_words.pop_front();
          if (m_tdata[2:0] !== got_word.kind) begin
            errors++;
            $display("%0t: out_kind expected %0d actual %0d",
                     $time, got_word.kind, m_tdata[2:0]);
          end
          if (m_tdata[10:3] !== got_word.data) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h",
                     $time, got_word.data, m_tdata[10:3]);
          end
          if (m_tlast !== got_word.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, got_word.last, m_tlast);
          end
          if (m_tdata[15:11] !== 5'd0) begin
            errors++;
            $display("%0t: pad bits expected 00 actual %h", $time, m_tdata[15:11]);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CH_TAB : CH_SPACE;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(9) == 0) return 8'($urandom_range(8'hFF, 8'h80));
    c = 8'($urandom_range(8'h7E, 8'h21));
    return (c == CH_COLON) ? 8'h2D : c;
  endfunction

  function automatic logic [7:0] value_char();
    case ($urandom_range(9))
      0: return 8'($urandom_range(8'hFF, 8'h80));
      1: return CH_COLON;
      2: return blank_char();
      default: return 8'($urandom_range(8'h7E, 8'h21));
    endcase
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  // one header of text: mostly well formed, some broken, some noise
  task automatic gen_text(output int useful);
    logic [7:0] txt[$];
    int nf;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      nf = $urandom_range(3);
      for (int f = 0; f < nf; f++) begin
        if ($urandom_range(7) == 0) repeat ($urandom_range(2, 1)) txt.push_back(blank_char());
        repeat ($urandom_range(4, 1)) txt.push_back(name_char());
        txt.push_back(CH_COLON);
        repeat ($urandom_range(2)) txt.push_back(blank_char());
        repeat ($urandom_range(5)) txt.push_back(value_char());
        if ($urandom_range(2) == 0) begin
          // folded continuation line
          txt.push_back(CH_NL);
          repeat ($urandom_range(2, 1)) txt.push_back(blank_char());
          repeat ($urandom_range(3)) txt.push_back(value_char());
        end
        if (f != nf - 1 || $urandom_range(1)) txt.push_back(CH_NL);
      end
      useful = txt.size() + 1;
      if ($urandom_range(1) && (txt.size() == 0 || txt[txt.size() - 1] == CH_NL)) begin
        // blank line, then a body that is ignored
        txt.push_back(CH_NL);
        repeat ($urandom_range(4)) txt.push_back(8'($urandom_range(255, 1)));
      end
    end else if (pick < 90) begin
      // field with no colon, then random bytes
      repeat ($urandom_range(4, 1)) txt.push_back(name_char());
      repeat ($urandom_range(1)) txt.push_back(blank_char());
      if ($urandom_range(1)) txt.push_back(CH_NL);
      useful = txt.size() + 1;
      repeat ($urandom_range(4)) txt.push_back(8'($urandom_range(255, 1)));
    end else begin
      repeat ($urandom_range(8, 1)) txt.push_back(8'($urandom_range(255)));
      useful = txt.size() + 1;
    end
    txt.push_back(CH_NUL);
    foreach (txt[i]) text_bytes.push_back(txt[i]);
  endtask

  task automatic wait_sent();
    while (text_bytes.size() != 0 || s_tvalid) @(negedge clk);
  endtask

  task automatic run_random(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      gen_text(counted);
      sent += counted;
    end
    wait_sent();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    snd_idle = 20;
    rcv_idle = 83;

    // directed: empty header
    text_bytes.push_back(CH_NUL);
    // blank line first, then end of text while skipping (silent)
    push_str("\n");
    text_bytes.push_back(CH_NUL);
    // blanks dropped at value start, folded line, end of text in a field
    push_str("a:\t b\n\tc");
    text_bytes.push_back(CH_NUL);
    // leading blank of a field, then missing colon
    push_str(" x\n\n");
    text_bytes.push_back(CH_NUL);
    // extreme bytes; end of text inside a fold gives three words
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(CH_COLON);
    text_bytes.push_back(8'h80);
    push_str("\n ");
    text_bytes.push_back(CH_NUL);
    // blank line ends the header, body ignored
    push_str("k:v\n\nZ");
    text_bytes.push_back(CH_NUL);
    wait_sent();

    run_random(100);
    snd_idle = 83;
    rcv_idle = 20;
    run_random(100);
    snd_idle = 0;
    rcv_idle = 0;
    hold_seq++;   // receiver stalls while the sender keeps offering
    run_random(100);

    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
